// ===== design/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared widths, constants, types and tables of the euler to quaternion block
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_W         = 16;
  localparam int QUAT_W          = 16;
  localparam int QFRAC           = QUAT_W - 2;
  localparam int TRIG_STAGES_DEF = 16;

  // angle reduction, 720 degrees in 1/128 degree units
  localparam int R_W        = 17;
  localparam int DEG720     = 92160;
  localparam int DIV45      = 45;
  localparam int RECIP45    = 186413;  // floor(2^23 / 45)
  localparam int RECIP_SH   = 23;
  localparam int A_W        = 11;
  localparam int REM_W      = 7;
  localparam int FRAC_TBL_W = 21;

  // cordic
  localparam int CORDIC_W      = 32;
  localparam int Z_W           = 33;
  localparam int CORDIC_OUT_SH = 9;
  localparam int TRIG_W        = 22;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = CORDIC_W'(32'sh2000_0000);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // products and normalisation
  localparam int PROD_SH = 20;
  localparam int PAIR_W  = 24;
  localparam int TRI_W   = 46;
  localparam int Q_W     = 26;
  localparam int MAG_W   = Q_W - 1;
  localparam int SS_W    = 50;
  localparam int ROOT_W  = SS_W / 2;
  localparam int QUO_W   = QFRAC + 1;
  localparam int NUM_W   = MAG_W + QFRAC + 1;
  localparam logic [QUO_W-1:0] QUO_LIM = QUO_W'(1) << QFRAC;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;

  typedef struct packed {
    logic en;
    logic vld;
  } e2q_ctl_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10680862,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0
  };

  // floor((b * 2^21 + 22) / 45) for a remainder b of 0 to 44
  function automatic logic [FRAC_TBL_W-1:0] phase_frac(input logic [REM_W-1:0] b);
    logic [FRAC_TBL_W-1:0] v;
    unique case (b)
      7'd0:  v = 21'd0;       7'd1:  v = 21'd46603;   7'd2:  v = 21'd93207;
      7'd3:  v = 21'd139810;  7'd4:  v = 21'd186414;  7'd5:  v = 21'd233017;
      7'd6:  v = 21'd279620;  7'd7:  v = 21'd326224;  7'd8:  v = 21'd372827;
      7'd9:  v = 21'd419430;  7'd10: v = 21'd466034;  7'd11: v = 21'd512637;
      7'd12: v = 21'd559241;  7'd13: v = 21'd605844;  7'd14: v = 21'd652447;
      7'd15: v = 21'd699051;  7'd16: v = 21'd745654;  7'd17: v = 21'd792257;
      7'd18: v = 21'd838861;  7'd19: v = 21'd885464;  7'd20: v = 21'd932068;
      7'd21: v = 21'd978671;  7'd22: v = 21'd1025274; 7'd23: v = 21'd1071878;
      7'd24: v = 21'd1118481; 7'd25: v = 21'd1165084; 7'd26: v = 21'd1211688;
      7'd27: v = 21'd1258291; 7'd28: v = 21'd1304895; 7'd29: v = 21'd1351498;
      7'd30: v = 21'd1398101; 7'd31: v = 21'd1444705; 7'd32: v = 21'd1491308;
      7'd33: v = 21'd1537911; 7'd34: v = 21'd1584515; 7'd35: v = 21'd1631118;
      7'd36: v = 21'd1677722; 7'd37: v = 21'd1724325; 7'd38: v = 21'd1770928;
      7'd39: v = 21'd1817532; 7'd40: v = 21'd1864135; 7'd41: v = 21'd1910738;
      7'd42: v = 21'd1957342; 7'd43: v = 21'd2003945; 7'd44: v = 21'd2050549;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/e2q_angle_if.sv =====
// ----------------------------------------------------------------------------
// e2q_angle_if
// Valid/ready channel carrying one roll, pitch, yaw triple per beat
// ----------------------------------------------------------------------------
interface e2q_angle_if
  import e2q_pkg::*;
();
  logic   valid;
  logic   ready;
  angle_t roll_angle;
  angle_t pitch_angle;
  angle_t yaw_angle;

  modport source (output valid, output roll_angle, output pitch_angle,
                  output yaw_angle, input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle,
                  input yaw_angle, output ready);
endinterface

// ===== design/e2q_quat_if.sv =====
// ----------------------------------------------------------------------------
// e2q_quat_if
// Valid/ready channel carrying one quaternion per beat
// ----------------------------------------------------------------------------
interface e2q_quat_if
  import e2q_pkg::*;
();
  logic  valid;
  logic  ready;
  quat_t quat_w;
  quat_t quat_x;
  quat_t quat_y;
  quat_t quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface

// ===== design/e2q_half_trig.sv =====
// ----------------------------------------------------------------------------
// e2q_half_trig
// Half-angle phase reduction and pipelined cordic, one stage per iteration
// ----------------------------------------------------------------------------
module e2q_half_trig
  import e2q_pkg::*;
#(
  parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  e2q_ctl_t ctl,
  input  angle_t   angle,
  output trig_t    cs,
  output trig_t    sn,
  output logic     vld
);

  // stage 1: wrap into 0 .. 720 degrees
  logic signed [R_W:0] ang_ext;
  logic [R_W-1:0]      r_wrap;
  logic [R_W-1:0]      r1;
  logic                v1;

  assign ang_ext = {{(R_W + 1 - ANGLE_W){angle[ANGLE_W-1]}}, angle};
  assign r_wrap  = angle[ANGLE_W-1] ? R_W'(ang_ext + (R_W + 1)'(DEG720)) : R_W'(ang_ext);

  // stage 2: quotient estimate by reciprocal
  logic [R_W+17:0] r_prod;
  logic [R_W-1:0]  r2;
  logic [A_W-1:0]  a2;
  logic            v2;

  assign r_prod = (R_W + 18)'(r1) * (R_W + 18)'(RECIP45);

  // stage 3: correct quotient, form the phase
  logic [R_W-1:0]   rem_full;
  logic [REM_W-1:0] rem_b;
  logic [A_W-1:0]   a_fix;
  logic [31:0]      phase_c;
  logic [31:0]      phase3;
  logic             v3;

  always_comb begin
    rem_full = r2 - R_W'(a2) * R_W'(DIV45);
    if (rem_full >= R_W'(DIV45)) begin
      rem_b = REM_W'(rem_full - R_W'(DIV45));
      a_fix = a2 + A_W'(1);
    end else begin
      rem_b = REM_W'(rem_full);
      a_fix = a2;
    end
    phase_c = {a_fix, {FRAC_TBL_W{1'b0}}} + 32'(phase_frac(rem_b));
  end

  // stage 4 feeds the cordic: nearest quadrant and residual phase
  logic [1:0]  quad_c;
  logic [31:0] d_c;
  logic [31:0] phase_rnd;

  assign phase_rnd = phase3 + 32'h2000_0000;
  assign quad_c    = phase_rnd[31:30];
  assign d_c       = phase3 - {quad_c, 30'b0};

  logic signed [CORDIC_W-1:0] cx [TRIG_STAGES+1];
  logic signed [CORDIC_W-1:0] cy [TRIG_STAGES+1];
  logic signed [Z_W-1:0]      cz [TRIG_STAGES+1];
  logic [1:0]                 cq [TRIG_STAGES+1];
  logic                       cv [TRIG_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      cv[0] <= 1'b0;
    end else if (ctl.en) begin
      v1    <= ctl.vld;
      v2    <= v1;
      v3    <= v2;
      cv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      r1    <= r_wrap;
      r2    <= r1;
      a2    <= r_prod[RECIP_SH +: A_W];
      phase3 <= phase_c;
      cx[0] <= CORDIC_X0;
      cy[0] <= '0;
      cz[0] <= {d_c[31], d_c};
      cq[0] <= quad_c;
    end
  end

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [Z_W-1:0]      at;

    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    assign at = Z_W'(ATAN_TURNS[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (ctl.en) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        cq[i+1] <= cq[i];
        if (!cz[i][Z_W-1]) begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          cz[i+1] <= cz[i] - at;
        end else begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          cz[i+1] <= cz[i] + at;
        end
      end
    end
  end

  // output stage: scale down and undo the quadrant rotation
  trig_t xs;
  trig_t ys;
  trig_t cs_c;
  trig_t sn_c;

  assign xs = TRIG_W'(cx[TRIG_STAGES] >>> CORDIC_OUT_SH);
  assign ys = TRIG_W'(cy[TRIG_STAGES] >>> CORDIC_OUT_SH);

  always_comb begin
    unique case (cq[TRIG_STAGES])
      QUAD_1: begin
        cs_c = -ys;
        sn_c = xs;
      end
      QUAD_2: begin
        cs_c = -xs;
        sn_c = -ys;
      end
      QUAD_3: begin
        cs_c = ys;
        sn_c = -xs;
      end
      default: begin
        cs_c = xs;
        sn_c = ys;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.en) begin
      vld <= cv[TRIG_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      cs <= cs_c;
      sn <= sn_c;
    end
  end

endmodule

// ===== design/e2q_quat_mul.sv =====
// ----------------------------------------------------------------------------
// e2q_quat_mul
// Quaternion products, magnitudes and sum of squares over five stages
// ----------------------------------------------------------------------------
module e2q_quat_mul
  import e2q_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  e2q_ctl_t                    ctl,
  input  trig_t                       cs_x,
  input  trig_t                       sn_x,
  input  trig_t                       cs_y,
  input  trig_t                       sn_y,
  input  trig_t                       cs_z,
  input  trig_t                       sn_z,
  output logic [SS_W-1:0]             ss,
  output logic [3:0][MAG_W-1:0]       mag,
  output logic [3:0]                  neg,
  output logic                        vld
);

  // stage 1: pair products of yaw and pitch terms
  logic signed [2*TRIG_W-1:0] m_cc, m_ss, m_sc, m_cs;
  logic signed [PAIR_W-1:0]   p_cc, p_ss, p_sc, p_cs;
  trig_t                      p_cz, p_sz;
  logic                       v1;

  assign m_cc = cs_x * cs_y;
  assign m_ss = sn_x * sn_y;
  assign m_sc = sn_x * cs_y;
  assign m_cs = cs_x * sn_y;

  // stage 2: triple products, a and b terms of w, x, y, z
  logic signed [TRI_W-1:0] t_a [4];
  logic signed [TRI_W-1:0] t_b [4];
  logic                    v2;

  // stage 3: combine and scale
  logic signed [TRI_W:0]  s_c [4];
  logic signed [Q_W-1:0]  qv [4];
  logic                   v3;

  assign s_c[0] = (TRI_W + 1)'(t_a[0]) + (TRI_W + 1)'(t_b[0]);
  assign s_c[1] = (TRI_W + 1)'(t_a[1]) - (TRI_W + 1)'(t_b[1]);
  assign s_c[2] = (TRI_W + 1)'(t_a[2]) + (TRI_W + 1)'(t_b[2]);
  assign s_c[3] = (TRI_W + 1)'(t_a[3]) - (TRI_W + 1)'(t_b[3]);

  // stage 4: squares and magnitudes
  logic signed [2*Q_W-1:0] sq_c [4];
  logic [SS_W-1:0]         sq [4];
  logic [3:0][MAG_W-1:0]   mag4;
  logic [3:0]              neg4;
  logic                    v4;

  for (genvar k = 0; k < 4; k++) begin : g_sq
    assign sq_c[k] = qv[k] * qv[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      vld <= 1'b0;
    end else if (ctl.en) begin
      v1  <= ctl.vld;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      vld <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      p_cc <= PAIR_W'(m_cc >>> PROD_SH);
      p_ss <= PAIR_W'(m_ss >>> PROD_SH);
      p_sc <= PAIR_W'(m_sc >>> PROD_SH);
      p_cs <= PAIR_W'(m_cs >>> PROD_SH);
      p_cz <= cs_z;
      p_sz <= sn_z;

      t_a[0] <= p_cc * p_cz;
      t_b[0] <= p_ss * p_sz;
      t_a[1] <= p_sc * p_cz;
      t_b[1] <= p_cs * p_sz;
      t_a[2] <= p_cs * p_cz;
      t_b[2] <= p_sc * p_sz;
      t_a[3] <= p_cc * p_sz;
      t_b[3] <= p_ss * p_cz;

      for (int k = 0; k < 4; k++) begin
        qv[k]   <= Q_W'(s_c[k] >>> PROD_SH);
        sq[k]   <= SS_W'(sq_c[k]);
        neg4[k] <= qv[k][Q_W-1];
        mag4[k] <= qv[k][Q_W-1] ? MAG_W'(-qv[k]) : MAG_W'(qv[k]);
      end

      ss  <= sq[0] + sq[1] + sq[2] + sq[3];
      mag <= mag4;
      neg <= neg4;
    end
  end

endmodule

// ===== design/e2q_norm.sv =====
// ----------------------------------------------------------------------------
// e2q_norm
// Pipelined integer square root and restoring divide, one bit per stage
// ----------------------------------------------------------------------------
module e2q_norm
  import e2q_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  e2q_ctl_t              ctl,
  input  logic [SS_W-1:0]       ss,
  input  logic [3:0][MAG_W-1:0] mag,
  input  logic [3:0]            neg,
  output quat_t                 quat_w,
  output quat_t                 quat_x,
  output quat_t                 quat_y,
  output quat_t                 quat_z,
  output logic                  vld
);

  logic [SS_W-1:0]       sv   [ROOT_W];
  logic [SS_W-1:0]       sres [ROOT_W];
  logic [3:0][MAG_W-1:0] smag [ROOT_W];
  logic [3:0]            sneg [ROOT_W];
  logic                  svld [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam logic [SS_W-1:0] BIT = SS_W'(1) << (SS_W - 2 - 2 * j);
    logic [SS_W-1:0]       v_in, r_in, trial;
    logic [3:0][MAG_W-1:0] m_in;
    logic [3:0]            n_in;
    logic                  vl_in;

    if (j == 0) begin : g_first
      assign v_in  = ss;
      assign r_in  = '0;
      assign m_in  = mag;
      assign n_in  = neg;
      assign vl_in = ctl.vld;
    end else begin : g_next
      assign v_in  = sv[j-1];
      assign r_in  = sres[j-1];
      assign m_in  = smag[j-1];
      assign n_in  = sneg[j-1];
      assign vl_in = svld[j-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        svld[j] <= 1'b0;
      end else if (ctl.en) begin
        svld[j] <= vl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        smag[j] <= m_in;
        sneg[j] <= n_in;
        if (v_in >= trial) begin
          sv[j]   <= v_in - trial;
          sres[j] <= (r_in >> 1) + BIT;
        end else begin
          sv[j]   <= v_in;
          sres[j] <= r_in >> 1;
        end
      end
    end
  end

  // rounding term folded into the numerator
  logic [ROOT_W-1:0]     root;
  logic [3:0][NUM_W-1:0] p_num;
  logic [ROOT_W-1:0]     p_norm;
  logic                  p_nz;
  logic [3:0]            p_neg;
  logic                  p_vld;

  assign root = sres[ROOT_W-1][ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (ctl.en) begin
      p_vld <= svld[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int k = 0; k < 4; k++) begin
        p_num[k] <= (NUM_W'(smag[ROOT_W-1][k]) << QFRAC) + NUM_W'(root >> 1);
      end
      p_norm <= root;
      p_nz   <= (root != '0);
      p_neg  <= sneg[ROOT_W-1];
    end
  end

  logic [3:0][NUM_W-1:0] drem  [QUO_W];
  logic [3:0][QUO_W-1:0] dquo  [QUO_W];
  logic [ROOT_W-1:0]     dnorm [QUO_W];
  logic                  dnz   [QUO_W];
  logic [3:0]            dneg  [QUO_W];
  logic                  dvld  [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    localparam int SH = QUO_W - 1 - j;
    logic [3:0][NUM_W-1:0] rem_in, rem_nx;
    logic [3:0][QUO_W-1:0] quo_in, quo_nx;
    logic [ROOT_W-1:0]     nrm_in;
    logic                  nz_in;
    logic [3:0]            ng_in;
    logic                  vl_in;
    logic [NUM_W-1:0]      dsh;

    if (j == 0) begin : g_first
      assign rem_in = p_num;
      assign quo_in = '0;
      assign nrm_in = p_norm;
      assign nz_in  = p_nz;
      assign ng_in  = p_neg;
      assign vl_in  = p_vld;
    end else begin : g_next
      assign rem_in = drem[j-1];
      assign quo_in = dquo[j-1];
      assign nrm_in = dnorm[j-1];
      assign nz_in  = dnz[j-1];
      assign ng_in  = dneg[j-1];
      assign vl_in  = dvld[j-1];
    end

    assign dsh = NUM_W'(nrm_in) << SH;

    always_comb begin
      for (int k = 0; k < 4; k++) begin
        if (rem_in[k] >= dsh) begin
          rem_nx[k] = rem_in[k] - dsh;
          quo_nx[k] = {quo_in[k][QUO_W-2:0], 1'b1};
        end else begin
          rem_nx[k] = rem_in[k];
          quo_nx[k] = {quo_in[k][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[j] <= 1'b0;
      end else if (ctl.en) begin
        dvld[j] <= vl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        drem[j]  <= rem_nx;
        dquo[j]  <= quo_nx;
        dnorm[j] <= nrm_in;
        dnz[j]   <= nz_in;
        dneg[j]  <= ng_in;
      end
    end
  end

  // saturate, apply sign, identity on a zero norm
  quat_t comp [4];

  always_comb begin
    logic [QUO_W-1:0] qs;
    for (int k = 0; k < 4; k++) begin
      qs      = (dquo[QUO_W-1][k] > QUO_LIM) ? QUO_LIM : dquo[QUO_W-1][k];
      comp[k] = dneg[QUO_W-1][k] ? -QUAT_W'(qs) : QUAT_W'(qs);
    end
    if (!dnz[QUO_W-1]) begin
      comp[0] = QUAT_W'(QUO_LIM);
      comp[1] = '0;
      comp[2] = '0;
      comp[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.en) begin
      vld <= dvld[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      quat_w <= comp[0];
      quat_x <= comp[1];
      quat_y <= comp[2];
      quat_z <= comp[3];
    end
  end

endmodule

// ===== design/euler_to_quaternion.sv =====
// throughput: one beat per cycle while the output is not stalled, set by the
// fully pipelined cordic, root and divide
// all stages advance together; a stalled output holds the whole pipeline
// reset: synchronous, clears every valid bit, data registers are not reset
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Roll, pitch and yaw in 1/128 degree to a normalised Q1.14 quaternion
// ----------------------------------------------------------------------------
module euler_to_quaternion
  import e2q_pkg::*;
#(
  parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  e2q_angle_if.sink     angles,
  e2q_quat_if.source    quat
);

  logic     en;
  e2q_ctl_t ctl_in, ctl_trig, ctl_norm;
  trig_t    cs_roll, sn_roll, cs_pitch, sn_pitch, cs_yaw, sn_yaw;
  logic     v_roll, v_pitch, v_yaw;

  logic [SS_W-1:0]       ss;
  logic [3:0][MAG_W-1:0] mag;
  logic [3:0]            neg;
  logic                  qm_vld;

  // pipeline moves whenever the output register is free or being drained
  assign en           = !quat.valid || quat.ready;
  assign angles.ready = en;

  assign ctl_in   = '{en: en, vld: angles.valid};
  assign ctl_trig = '{en: en, vld: v_roll & v_pitch & v_yaw};
  assign ctl_norm = '{en: en, vld: qm_vld};

  e2q_half_trig #(.TRIG_STAGES(TRIG_STAGES)) u_trig_roll (
    .clk(clk), .rst(rst), .ctl(ctl_in), .angle(angles.roll_angle),
    .cs(cs_roll), .sn(sn_roll), .vld(v_roll)
  );

  e2q_half_trig #(.TRIG_STAGES(TRIG_STAGES)) u_trig_pitch (
    .clk(clk), .rst(rst), .ctl(ctl_in), .angle(angles.pitch_angle),
    .cs(cs_pitch), .sn(sn_pitch), .vld(v_pitch)
  );

  e2q_half_trig #(.TRIG_STAGES(TRIG_STAGES)) u_trig_yaw (
    .clk(clk), .rst(rst), .ctl(ctl_in), .angle(angles.yaw_angle),
    .cs(cs_yaw), .sn(sn_yaw), .vld(v_yaw)
  );

  // x is yaw, y is pitch, z is roll
  e2q_quat_mul u_quat_mul (
    .clk(clk), .rst(rst), .ctl(ctl_trig),
    .cs_x(cs_yaw), .sn_x(sn_yaw), .cs_y(cs_pitch), .sn_y(sn_pitch),
    .cs_z(cs_roll), .sn_z(sn_roll),
    .ss(ss), .mag(mag), .neg(neg), .vld(qm_vld)
  );

  e2q_norm u_norm (
    .clk(clk), .rst(rst), .ctl(ctl_norm), .ss(ss), .mag(mag), .neg(neg),
    .quat_w(quat.quat_w), .quat_x(quat.quat_x), .quat_y(quat.quat_y),
    .quat_z(quat.quat_z), .vld(quat.valid)
  );

endmodule

// ===== design/e2q_checker.sv =====
// ----------------------------------------------------------------------------
// e2q_checker
// Port-level checks of the euler to quaternion block, bound to the top level
// ----------------------------------------------------------------------------
module e2q_checker
  import e2q_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input quat_t quat_w,
  input quat_t quat_x,
  input quat_t quat_y,
  input quat_t quat_z
);

  localparam quat_t LIM = QUAT_W'(QUO_LIM);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_x)
      && $stable(quat_y) && $stable(quat_z))
    else $error("output beat changed while stalled");

  // output register free means input ready
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // every component stays within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quat_w <= LIM && quat_w >= -LIM && quat_x <= LIM && quat_x >= -LIM
      && quat_y <= LIM && quat_y >= -LIM && quat_z <= LIM && quat_z >= -LIM)
    else $error("quaternion component out of range");

  // an accepted input beat never leaves the output valid unknown
  a_in_known: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$isunknown(out_valid))
    else $error("output valid unknown after input beat");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
  .clk(clk), .rst(rst),
  .in_valid(angles.valid), .in_ready(angles.ready),
  .out_valid(quat.valid), .out_ready(quat.ready),
  .quat_w(quat.quat_w), .quat_x(quat.quat_x),
  .quat_y(quat.quat_y), .quat_z(quat.quat_z)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for euler_to_quaternion: each accepted angle triple
// without a fixed quaternion runs through a bit-true model of the half-angle
// cordic, triple products and normalisation; each beat is compared in order
// ----------------------------------------------------------------------------
module tb_top;
  import e2q_pkg::*;

  typedef struct packed {
    quat_t w;
    quat_t x;
    quat_t y;
    quat_t z;
  } quat_beat_t;

  typedef struct packed {
    angle_t     roll;
    angle_t     pitch;
    angle_t     yaw;
    logic       fixed;
    quat_beat_t q;
  } angle_row_t;

  localparam int   N_RANDOM  = 1550;
  localparam int   TAIL_WAIT = 200;
  localparam quat_t ONE      = quat_t'(1 << QFRAC);

  logic clk = 1'b0;
  logic rst = 1'b1;

  e2q_angle_if angles ();
  e2q_quat_if  quat ();

  euler_to_quaternion DUT (
    .clk    (clk),
    .rst    (rst),
    .angles (angles.sink),
    .quat   (quat.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quat_beat_t pending_quats[$];
  int         mismatches = 0;
  int         sender_idle_pct = 0;
  int         sink_stall_pct = 0;
  logic       long_hold_req = 1'b0;
  logic       row_fixed = 1'b0;
  quat_beat_t row_quat = '0;

  // cosine and sine of half the angle, cordic gain times 2^20
  function automatic void half_angle_trig(input longint ang, output longint cs,
                                          output longint sn);
    longint          r, z, x, y, t, dx, dy;
    longint unsigned num;
    logic [31:0]     phase, d;
    logic [1:0]      quad;
    r = ang % DEG720;
    if (r < 0) r += DEG720;
    num   = (longint'(r) << 32) + (DEG720 / 2);
    phase = 32'(num / DEG720);
    quad  = 2'((phase + 32'h2000_0000) >> 30);
    d     = phase - {quad, 30'b0};
    z     = d[31] ? longint'(d) - (64'sd1 <<< 32) : longint'(d);
    x     = 64'sd1 <<< 29;
    y     = 0;
    for (int i = 0; i < TRIG_STAGES_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
      end
    end
    x = x >>> CORDIC_OUT_SH;
    y = y >>> CORDIC_OUT_SH;
    case (quad)
      QUAD_1: begin
        t = x; x = -y; y = t;
      end
      QUAD_2: begin
        x = -x; y = -y;
      end
      QUAD_3: begin
        t = x; x = y; y = -t;
      end
      default: ;
    endcase
    cs = x;
    sn = y;
  endfunction

  function automatic longint triple(input longint a, input longint b, input longint c);
    return ((a * b) >>> PROD_SH) * c;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic quat_t scale_part(input longint v, input longint unsigned norm);
    longint unsigned mag, qq;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    qq  = ((mag << QFRAC) + norm / 2) / norm;
    if (qq > (64'd1 << QFRAC)) qq = 64'd1 << QFRAC;
    return (v < 0) ? quat_t'(-longint'(qq)) : quat_t'(qq);
  endfunction

  function automatic quat_beat_t angles_to_quat(input angle_t roll, input angle_t pitch,
                                                input angle_t yaw);
    longint          cz, sz, cy, sy, cx, sx, w, x, y, z;
    longint unsigned ss, norm;
    quat_beat_t      o;
    half_angle_trig(longint'(roll), cz, sz);
    half_angle_trig(longint'(pitch), cy, sy);
    half_angle_trig(longint'(yaw), cx, sx);
    w = (triple(cx, cy, cz) + triple(sx, sy, sz)) >>> PROD_SH;
    x = (triple(sx, cy, cz) - triple(cx, sy, sz)) >>> PROD_SH;
    y = (triple(cx, sy, cz) + triple(sx, cy, sz)) >>> PROD_SH;
    z = (triple(cx, cy, sz) - triple(sx, sy, cz)) >>> PROD_SH;
    ss   = w * w + x * x + y * y + z * z;
    norm = int_sqrt(ss);
    if (norm == 0) begin
      o = '{w: ONE, x: '0, y: '0, z: '0};
    end else begin
      o.w = scale_part(w, norm);
      o.x = scale_part(x, norm);
      o.y = scale_part(y, norm);
      o.z = scale_part(z, norm);
    end
    return o;
  endfunction

  // input and output beats seen at the same edge
  always @(posedge clk) begin
    quat_beat_t got, want;
    if (!rst && quat.valid && quat.ready) begin
      got = '{w: quat.quat_w, x: quat.quat_x, y: quat.quat_y, z: quat.quat_z};
      if (pending_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected quaternion beat w=%0d x=%0d y=%0d z=%0d",
                   got.w, got.x, got.y, got.z);
      end else begin
        want = pending_quats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("quaternion mismatch exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                     want.w, want.x, want.y, want.z, got.w, got.x, got.y, got.z);
        end
      end
    end
    if (!rst && angles.valid && angles.ready)
      pending_quats.push_back(row_fixed ? row_quat :
          angles_to_quat(angles.roll_angle, angles.pitch_angle, angles.yaw_angle));
  end

  // sink side, with its own count for the long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    quat.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && hold_left == 0) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        quat.ready <= 1'b0;
      end else begin
        quat.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_angles(input angle_t roll, input angle_t pitch, input angle_t yaw,
                             input logic fixed, input quat_beat_t q);
    while ($urandom_range(99) < sender_idle_pct) begin
      angles.valid <= 1'b0;
      @(posedge clk);
    end
    angles.valid       <= 1'b1;
    angles.roll_angle  <= roll;
    angles.pitch_angle <= pitch;
    angles.yaw_angle   <= yaw;
    row_fixed          <= fixed;
    row_quat           <= q;
    do @(posedge clk); while (!angles.ready);
  endtask

  function automatic angle_t rand_angle();
    case ($urandom_range(9))
      0:       return angle_t'($urandom());
      1:       return angle_t'($urandom_range(2)) * 16'sd11520 - 16'sd23040 +
                      angle_t'($urandom_range(2)) - 16'sd1;
      default: return angle_t'(int'($urandom_range(46080)) - 23040);
    endcase
  endfunction

  angle_row_t directed_rows[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{ONE, 16'sd0, 16'sd0, 16'sd0}},
    '{16'sd23040, 16'sd0, 16'sd0, 1'b0, '0},
    '{-16'sd23040, 16'sd0, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sd23040, 16'sd0, 1'b0, '0},
    '{16'sd0, -16'sd23040, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sd23040, 1'b0, '0},
    '{16'sd0, 16'sd0, -16'sd23040, 1'b0, '0},
    '{16'sd11520, 16'sd11520, 16'sd11520, 1'b0, '0},
    '{-16'sd11520, 16'sd11520, -16'sd11520, 1'b0, '0},
    '{16'sd5760, -16'sd5760, 16'sd5760, 1'b0, '0},
    '{16'sd23040, 16'sd23040, 16'sd23040, 1'b0, '0},
    '{-16'sd23040, -16'sd23040, -16'sd23040, 1'b0, '0},
    // beyond half a turn, wraps on the 720 degree period
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '0},
    '{-16'sh8000, -16'sh8000, -16'sh8000, 1'b0, '0},
    '{16'sh7fff, -16'sh8000, 16'sd0, 1'b0, '0},
    '{16'sd1, -16'sd1, 16'sd1, 1'b0, '0},
    '{16'sd23039, 16'sd17280, -16'sd17280, 1'b0, '0},
    '{16'sd2880, 16'sd8640, 16'sd14400, 1'b0, '0},
    '{16'sh5555, -16'sh2aab, 16'sh2aaa, 1'b0, '0}
  };

  initial begin
    angles.valid       <= 1'b0;
    angles.roll_angle  <= '0;
    angles.pitch_angle <= '0;
    angles.yaw_angle   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_angles(directed_rows[i].roll, directed_rows[i].pitch, directed_rows[i].yaw,
                  directed_rows[i].fixed, directed_rows[i].q);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 64; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 64; end
        default: begin sender_idle_pct = 30; sink_stall_pct = 30; end
      endcase
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        // long sink hold-off while beats keep coming, fills the pipe
        if (ph == 0 && n == 40) long_hold_req <= 1'b1;
        if (ph == 0 && n == 41) long_hold_req <= 1'b0;
        send_angles(rand_angle(), rand_angle(), rand_angle(), 1'b0, '0);
      end
      if (ph == 1) begin
        angles.valid <= 1'b0;
        while (pending_quats.size() != 0) @(posedge clk);
      end
    end
    angles.valid <= 1'b0;

    while (pending_quats.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_quats.size() == 0)
      $display("euler_to_quaternion verification clean");
    else
      $display("euler_to_quaternion verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("euler_to_quaternion verification failed");
    $finish;
  end

endmodule
